FILE: hw/rtl/sib_pkg.sv
// Shared types and constants of the scaled image blitter.
// No dependencies; imported by every module of the block.
package sib_pkg;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned LAYOUT_W  = 11;
  localparam int unsigned DIV_W     = 42;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIM_W-1:0] ChanMax = 13'd255;

  typedef enum logic [2:0] {
    CFG_SRC_W   = 3'd0,
    CFG_SRC_H   = 3'd1,
    CFG_SCR_W   = 3'd2,
    CFG_SCR_H   = 3'd3,
    CFG_DEPTH   = 3'd4,
    CFG_RED     = 3'd5,
    CFG_GREEN   = 3'd6,
    CFG_BLUE    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DEPTH_32  = 2'd0,
    DEPTH_24  = 2'd1,
    DEPTH_16  = 2'd2,
    DEPTH_OFF = 2'd3
  } depth_e;

  typedef struct packed {
    logic [DIM_W-1:0]    source_width;
    logic [DIM_W-1:0]    source_height;
    logic [DIM_W-1:0]    screen_width;
    logic [DIM_W-1:0]    screen_height;
    depth_e              depth_mode;
    logic [LAYOUT_W-1:0] red_layout;
    logic [LAYOUT_W-1:0] green_layout;
    logic [LAYOUT_W-1:0] blue_layout;
  } cfg_t;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] screen_col;
    logic [POS_W-1:0] screen_row;
    logic [31:0]      pixel_value;
    logic             last_write;
  } wr_t;

endpackage

FILE: hw/rtl/sib_front.sv
// Front end: accepts source pixel requests and holds them in a two-entry queue.
// Depends on sib_pkg.
module sib_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sib_pkg::item_t in_item_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output sib_pkg::item_t item_o
);
  import sib_pkg::*;

  item_t      mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rp_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: hw/rtl/sib_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sib_pkg.
module sib_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sib_pkg::DIV_W-1:0] num_i,
  input  logic [sib_pkg::DIM_W-1:0] den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [sib_pkg::DIV_W-1:0] quot_o
);
  import sib_pkg::*;

  logic [DIV_W-1:0]     dq_q;
  logic [DIM_W-1:0]     rem_q, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIM_W:0]       trial;
  logic                 ge;

  assign trial  = {rem_q, dq_q[DIV_W-1]};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      dq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DIM_W'(trial - {1'b0, den_q}) : trial[DIM_W-1:0];
      dq_q  <= {dq_q[DIV_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/sib_back.sv
// Back end: frame setup, pixel selection, packing and the output register.
// Depends on sib_pkg and sib_div.
module sib_back #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sib_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  sib_pkg::item_t item_i,
  output logic           wr_valid_o,
  input  logic           wr_ready_i,
  output sib_pkg::wr_t   wr_o
);
  import sib_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FS, S_FS_DX, S_FS_DY, S_FS_MW, S_FS_MH, S_FS_OFF, S_CHK,
    S_PK, S_PK_W, S_CV, S_CV_W, S_EMIT, S_PC, S_PC_W, S_SRC, S_PR_W
  } state_e;

  state_e           state_q;
  item_t            it_q;
  logic [DIM_W-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
  logic [DIM_W-1:0] pick_col_q, pick_row_q, out_w_q, out_h_q;
  logic [POS_W-1:0] off_col_q, off_row_q, col_q, row_q;
  logic [28:0]      sx_q;
  logic [15:0]      s_q;
  logic [1:0]       idx_q;
  logic [31:0]      px_q;
  logic [4:0]       rr_q, bb_q;
  logic [5:0]       gg_q;
  logic             row_hit_q, last_q;
  logic             wr_valid_q;
  wr_t              wr_q;
  logic [39:0]      fy_q, fq_q;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_num, div_quot;
  logic [DIM_W-1:0] div_den;

  logic [DIM_W-1:0]    w, h, sw, sh;
  logic                do_scale, sizes_ok;
  logic [CHAN_W-1:0]   chan;
  logic [LAYOUT_W-1:0] layout;
  logic [5:0]          shamt;
  logic [39:0]         chan_prod;
  logic [CHAN_W-1:0]   cv_byte;
  logic [5:0]          cv_mul;
  logic [13:0]         cv_prod;
  logic [DIM_W-1:0]    dst_col_n, dst_row_n, src_col_n;
  logic [DIM_W:0]      col_w, row_w;
  logic                row_hit, hit, emit;
  logic [28:0]         mw_prod, mh_prod;
  logic [28:0]         s_min;
  logic [31:0]         v_out;
  logic                out_free, wr_issue;
  logic                fold_done;
  logic [39:0]         fold_quot;

  assign sw = cfg_i.source_width;
  assign sh = cfg_i.source_height;
  assign w  = ({19'b0, cfg_i.screen_width} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                          : cfg_i.screen_width;
  assign h  = ({19'b0, cfg_i.screen_height} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : cfg_i.screen_height;
  assign do_scale = (sw > w) || (sh > h);
  assign sizes_ok = (cfg_i.red_layout[10:5] != 6'd0) &&
                    (cfg_i.green_layout[10:5] != 6'd0) &&
                    (cfg_i.blue_layout[10:5] != 6'd0);

  always_comb begin
    unique case (idx_q)
      2'd0:    begin chan = it_q.red;   layout = cfg_i.red_layout;   end
      2'd1:    begin chan = it_q.green; layout = cfg_i.green_layout; end
      default: begin chan = it_q.blue;  layout = cfg_i.blue_layout;  end
    endcase
    // c * (2^size - 1), mask size capped at 32
    shamt = (layout[10:5] >= 6'd32) ? 6'd32 : layout[10:5];
    chan_prod = ({32'b0, chan} << shamt) - {32'b0, chan};
    unique case (idx_q)
      2'd0:    begin cv_byte = px_q[23:16]; cv_mul = 6'd31; end
      2'd1:    begin cv_byte = px_q[15:8];  cv_mul = 6'd63; end
      default: begin cv_byte = px_q[7:0];   cv_mul = 6'd31; end
    endcase
    cv_prod = {6'b0, cv_byte} * {8'b0, cv_mul};
  end

  // divide by 255: x = 256a + b = 255a + (a + b), one fold per cycle
  assign fold_done = (fy_q[39:8] == '0);
  assign fold_quot = fq_q + {39'b0, (fy_q[7:0] == ChanMax[7:0])};

  assign dst_col_n = dst_col_q + 1'b1;
  assign dst_row_n = dst_row_q + 1'b1;
  assign src_col_n = src_col_q + 1'b1;
  assign col_w     = {2'b0, off_col_q} + {1'b0, dst_col_q};
  assign row_w     = {2'b0, off_row_q} + {1'b0, dst_row_q};
  assign row_hit   = (src_row_q == pick_row_q);
  assign hit       = row_hit && (src_col_q == pick_col_q) && (dst_col_q < out_w_q);
  assign emit      = hit && (cfg_i.depth_mode != DEPTH_OFF) &&
                     (col_w < {1'b0, w}) && (row_w < {1'b0, h});
  assign mw_prod   = {16'b0, sw} * {13'b0, s_q};
  assign mh_prod   = {16'b0, sh} * {13'b0, s_q};
  assign s_min     = (sx_q < div_quot[28:0]) ? sx_q : div_quot[28:0];
  assign out_free  = !wr_valid_q || wr_ready_i;
  assign wr_issue  = (state_q == S_EMIT) && out_free;

  always_comb begin
    unique case (cfg_i.depth_mode)
      DEPTH_32: v_out = px_q;
      DEPTH_24: v_out = {8'b0, px_q[23:0]};
      default:  v_out = {16'b0, rr_q, gg_q, bb_q};
    endcase
  end

  // operands for the shared divider
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_FS: begin
        div_start = (sw != '0) && (sh != '0) && do_scale;
        div_num   = {13'b0, w, 16'b0};
        div_den   = sw;
      end
      S_FS_DX: begin
        div_start = div_done;
        div_num   = {13'b0, h, 16'b0};
        div_den   = sh;
      end
      S_PC: begin
        div_start = 1'b1;
        div_num   = {16'b0, {13'b0, dst_col_n} * {13'b0, sw}};
        div_den   = out_w_q;
      end
      S_SRC: begin
        div_start = (src_col_n >= sw) && row_hit_q;
        div_num   = {16'b0, {13'b0, dst_row_n} * {13'b0, sh}};
        div_den   = out_h_q;
      end
      default: ;
    endcase
  end

  sib_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign item_ready_o = (state_q == S_IDLE);
  assign wr_valid_o   = wr_valid_q;
  assign wr_o         = wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      src_col_q  <= '0;
      src_row_q  <= '0;
      dst_col_q  <= '0;
      dst_row_q  <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      out_w_q    <= '0;
      out_h_q    <= '0;
      off_col_q  <= '0;
      off_row_q  <= '0;
      wr_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      wr_valid_q <= wr_issue || (wr_valid_q && !wr_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) state_q <= item_i.frame_start ? S_FS : S_CHK;
        end
        S_FS: begin
          src_col_q  <= '0;
          src_row_q  <= '0;
          dst_col_q  <= '0;
          dst_row_q  <= '0;
          pick_col_q <= '0;
          pick_row_q <= '0;
          off_col_q  <= '0;
          off_row_q  <= '0;
          if (sw == '0 || sh == '0) begin
            out_w_q <= '0;
            out_h_q <= '0;
            state_q <= S_CHK;
          end else if (do_scale) begin
            state_q <= S_FS_DX;
          end else begin
            out_w_q <= sw;
            out_h_q <= sh;
            state_q <= S_FS_OFF;
          end
        end
        S_FS_DX: if (div_done) state_q <= S_FS_DY;
        S_FS_DY: if (div_done) state_q <= S_FS_MW;
        S_FS_MW: begin
          out_w_q <= (mw_prod[28:16] == '0) ? DIM_W'(1) : mw_prod[28:16];
          state_q <= S_FS_MH;
        end
        S_FS_MH: begin
          out_h_q <= (mh_prod[28:16] == '0) ? DIM_W'(1) : mh_prod[28:16];
          state_q <= S_FS_OFF;
        end
        S_FS_OFF: begin
          off_col_q <= (w > out_w_q) ? POS_W'((w - out_w_q) >> 1) : '0;
          off_row_q <= (h > out_h_q) ? POS_W'((h - out_h_q) >> 1) : '0;
          state_q   <= S_CHK;
        end
        S_CHK: begin
          idx_q <= '0;
          if (out_w_q == '0 || out_h_q == '0 || dst_row_q >= out_h_q) begin
            state_q <= S_IDLE;
          end else if (emit) begin
            state_q <= sizes_ok ? S_PK
                     : (cfg_i.depth_mode == DEPTH_16) ? S_CV : S_EMIT;
          end else if (hit) begin
            state_q <= S_PC;
          end else begin
            state_q <= S_SRC;
          end
        end
        S_PK:   state_q <= S_PK_W;
        S_PK_W: begin
          if (fold_done) begin
            idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
            if (idx_q != 2'd2) state_q <= S_PK;
            else state_q <= (cfg_i.depth_mode == DEPTH_16) ? S_CV : S_EMIT;
          end
        end
        S_CV:   state_q <= S_CV_W;
        S_CV_W: begin
          if (fold_done) begin
            idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
            state_q <= (idx_q == 2'd2) ? S_EMIT : S_CV;
          end
        end
        S_EMIT: begin
          if (out_free) state_q <= S_PC;
        end
        S_PC: begin
          dst_col_q <= dst_col_n;
          state_q   <= S_PC_W;
        end
        S_PC_W: begin
          if (div_done) begin
            pick_col_q <= div_quot[DIM_W-1:0];
            state_q    <= S_SRC;
          end
        end
        S_SRC: begin
          if (src_col_n >= sw) begin
            src_col_q <= '0;
            src_row_q <= src_row_q + 1'b1;
            if (row_hit_q) begin
              dst_row_q  <= dst_row_n;
              dst_col_q  <= '0;
              pick_col_q <= '0;
              state_q    <= S_PR_W;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            src_col_q <= src_col_n;
            state_q   <= S_IDLE;
          end
        end
        S_PR_W: begin
          if (div_done) begin
            pick_row_q <= div_quot[DIM_W-1:0];
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) it_q <= item_i;
    if (state_q == S_FS_DX && div_done) sx_q <= div_quot[28:0];
    if (state_q == S_FS_DY && div_done) s_q <= (s_min == '0) ? 16'd1 : s_min[15:0];
    if (state_q == S_CHK) begin
      row_hit_q <= row_hit;
      col_q     <= col_w[POS_W-1:0];
      row_q     <= row_w[POS_W-1:0];
      last_q    <= ({1'b0, dst_col_q} + 1'b1 == {1'b0, out_w_q}) &&
                   ({1'b0, dst_row_q} + 1'b1 == {1'b0, out_h_q});
      px_q      <= sizes_ok ? 32'd0 : {8'b0, it_q.red, it_q.green, it_q.blue};
    end
    if (state_q == S_PK) begin
      fy_q <= chan_prod;
      fq_q <= '0;
    end else if (state_q == S_CV) begin
      fy_q <= {26'b0, cv_prod};
      fq_q <= '0;
    end else if ((state_q == S_PK_W || state_q == S_CV_W) && !fold_done) begin
      fq_q <= fq_q + {8'b0, fy_q[39:8]};
      fy_q <= {8'b0, fy_q[39:8]} + {32'b0, fy_q[7:0]};
    end
    if (state_q == S_PK_W && fold_done) px_q <= px_q | (fold_quot[31:0] << layout[4:0]);
    if (state_q == S_CV_W && fold_done) begin
      unique case (idx_q)
        2'd0:    rr_q <= fold_quot[4:0];
        2'd1:    gg_q <= fold_quot[5:0];
        default: bb_q <= fold_quot[4:0];
      endcase
    end
    if (wr_issue) begin
      wr_q.screen_col  <= col_q;
      wr_q.screen_row  <= row_q;
      wr_q.pixel_value <= v_out;
      wr_q.last_write  <= last_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |-> (out_w_q != '0 && dst_col_q < out_w_q))
    else $error("write issued outside scaled width");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FS_OFF) |-> (out_w_q != '0 && out_h_q != '0))
    else $error("frame setup produced empty size");

endmodule

FILE: hw/rtl/scaled_image_blitter_top.sv
// Top level of the scaled image blitter: configuration registers, front and back.
// Depends on sib_pkg, sib_front and sib_back.
//
//  channel   dir  signals                         payload
//  s_axis    in   tvalid tready tdata tuser       red, green, blue, frame_start
//  m_axis    out  tvalid tready tdata tlast       screen_col, screen_row, pixel_value
//  cfg       in   cfg_we_i cfg_idx_i cfg_data_i   register index and value
//
// One pixel at a time: a skipped pixel passes S_IDLE, S_CHK and S_SRC; the end of a
// picked row adds a pick division, and a selected pixel adds a pick division plus
// divide-by-255 folding for packing and for 565.
// A scaling frame start adds two scale-ratio divisions and S_FS_MW, S_FS_MH, S_FS_OFF.
// Reset is asynchronous, active low; no clearing pass. The two-entry input queue
// and the output register let either side stall independently.
module scaled_image_blitter_top #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // screen_col[11:0], screen_row[23:12],
                                      // pixel_value[55:24]
  output logic        m_axis_tlast,   // last_write
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import sib_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_ready;
  wr_t   wr;

  assign in_item.frame_start = s_axis_tuser;
  assign in_item.red         = s_axis_tdata[7:0];
  assign in_item.green       = s_axis_tdata[15:8];
  assign in_item.blue        = s_axis_tdata[23:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= 13'd0;
      cfg_q.source_height <= 13'd0;
      cfg_q.screen_width  <= 13'd1024;
      cfg_q.screen_height <= 13'd768;
      cfg_q.depth_mode    <= DEPTH_32;
      cfg_q.red_layout    <= 11'd528;
      cfg_q.green_layout  <= 11'd264;
      cfg_q.blue_layout   <= 11'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_W: cfg_q.source_width  <= cfg_data_i;
        CFG_SRC_H: cfg_q.source_height <= cfg_data_i;
        CFG_SCR_W: cfg_q.screen_width  <= cfg_data_i;
        CFG_SCR_H: cfg_q.screen_height <= cfg_data_i;
        CFG_DEPTH: cfg_q.depth_mode    <= depth_e'(cfg_data_i[1:0]);
        CFG_RED:   cfg_q.red_layout    <= cfg_data_i[10:0];
        CFG_GREEN: cfg_q.green_layout  <= cfg_data_i[10:0];
        CFG_BLUE:  cfg_q.blue_layout   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  sib_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (q_valid),
    .item_ready_i (q_ready),
    .item_o       (q_item)
  );

  sib_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .wr_valid_o   (m_axis_tvalid),
    .wr_ready_i   (m_axis_tready),
    .wr_o         (wr)
  );

  assign m_axis_tdata = {wr.pixel_value, wr.screen_row, wr.screen_col};
  assign m_axis_tlast = wr.last_write;

endmodule
